/* sv/shadow_dispatch_tiler_top_macros.svh */
// assertion helpers, clocked on i_clk with the synchronous reset masked
`ifndef SHADOW_DISPATCH_TILER_TOP_MACROS_SVH
`define SHADOW_DISPATCH_TILER_TOP_MACROS_SVH

// same-cycle implication
`define SDT_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("shadow dispatch tiler check failed");

// next-cycle implication
`define SDT_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("shadow dispatch tiler check failed");

`endif

/* sv/sdt_pkg.sv */
package sdt_pkg;

    localparam int WAVE_SIZE = 64;
    localparam int WAVE_SH   = $clog2(WAVE_SIZE);
    localparam int FP_LIMIT_LSB = (WAVE_SIZE * 131072) / 1000000;
    localparam int W_LIM     = (FP_LIMIT_LSB > 0) ? FP_LIMIT_LSB : 1;

    // pipelined divider geometry
    localparam int DIV_NW  = 62;
    localparam int DIV_DW  = 32;
    localparam int DIV_BPS = 2;
    localparam int DIV_LAT = DIV_NW / DIV_BPS;

    localparam int CFG_AW = 3;
    localparam logic [14:0] VW_RESET = 15'd1920;
    localparam logic [14:0] VH_RESET = 15'd1080;

    typedef enum logic {
        REG_VIEWPORT_WIDTH  = 1'b0,
        REG_VIEWPORT_HEIGHT = 1'b1
    } t_reg_idx;

endpackage

/* sv/sdt_if.sv */
interface sdt_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] light_proj_x;
    logic signed [31:0] light_proj_y;
    logic signed [31:0] light_proj_z;
    logic signed [31:0] light_proj_w;

    modport source (
        output valid, light_proj_x, light_proj_y, light_proj_z, light_proj_w,
        input  ready
    );
    modport sink (
        input  valid, light_proj_x, light_proj_y, light_proj_z, light_proj_w,
        output ready
    );
endinterface

interface sdt_out_if;
    logic               valid;
    logic               ready;
    logic signed [47:0] light_pixel_x;
    logic signed [47:0] light_pixel_y;
    logic signed [31:0] light_depth;
    logic               light_in_front;
    logic               dispatch_valid;
    logic [8:0]         groups_x;
    logic [8:0]         groups_y;
    logic signed [31:0] pixel_offset_x;
    logic signed [31:0] pixel_offset_y;
    logic               last;

    modport source (
        output valid, light_pixel_x, light_pixel_y, light_depth, light_in_front,
               dispatch_valid, groups_x, groups_y, pixel_offset_x, pixel_offset_y, last,
        input  ready
    );
    modport sink (
        input  valid, light_pixel_x, light_pixel_y, light_depth, light_in_front,
               dispatch_valid, groups_x, groups_y, pixel_offset_x, pixel_offset_y, last,
        output ready
    );
endinterface

/* sv/sdt_div.sv */
module sdt_div (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [sdt_pkg::DIV_NW-1:0]  i_num,
    input  logic [sdt_pkg::DIV_DW-1:0]  i_den,
    output logic [sdt_pkg::DIV_NW-1:0]  o_quo,
    output logic                        o_rem_nz
);
    import sdt_pkg::*;

    typedef struct packed {
        logic [DIV_DW-1:0] rem;
        logic [DIV_NW-1:0] qn;
    } t_div_st;

    function automatic t_div_st div_steps(input t_div_st s, input logic [DIV_DW-1:0] d);
        t_div_st         r;
        logic [DIV_DW:0] t;
        r = s;
        for (int i = 0; i < DIV_BPS; i++) begin
            t    = {r.rem, r.qn[DIV_NW-1]};
            r.qn = {r.qn[DIV_NW-2:0], 1'b0};
            if (t >= {1'b0, d}) begin
                t       = t - {1'b0, d};
                r.qn[0] = 1'b1;
            end
            r.rem = t[DIV_DW-1:0];
        end
        return r;
    endfunction

    t_div_st           r_st  [DIV_LAT];
    logic [DIV_DW-1:0] r_den [DIV_LAT-1];

    for (genvar k = 0; k < DIV_LAT; k++) begin : g_stage
        t_div_st           st_in;
        logic [DIV_DW-1:0] den_in;
        if (k == 0) begin : g_first
            assign st_in  = '{rem: '0, qn: i_num};
            assign den_in = i_den;
        end else begin : g_next
            assign st_in  = r_st[k-1];
            assign den_in = r_den[k-1];
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_st[k] <= div_steps(st_in, den_in);
            end
        end
        if (k < DIV_LAT - 1) begin : g_den
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_den[k] <= den_in;
                end
            end
        end
    end

    assign o_quo    = r_st[DIV_LAT-1].qn;
    assign o_rem_nz = |r_st[DIV_LAT-1].rem;

endmodule

/* sv/shadow_dispatch_tiler_top.sv */
// channel   | dir | word carries                                 | handshake
// i_light   | in  | projected light x, y, z, w (Q16.16)          | valid / ready
// o_disp    | out | light pixel, depth, one dispatch rectangle   | valid / ready
// apb       | in  | viewport_width at 0x0, viewport_height at 0x4| psel / penable
//
// a light is taken every cycle while the pipeline is not held
// each light gives 1 to 8 words, one per cycle while o_disp.ready is high, from the output stage
// the 31-stage divider (2 quotient bits per stage) sets the latency
// the whole pipeline holds while the output stage still has words to send
// synchronous reset clears all valid bits and loads 1920 x 1080
`include "shadow_dispatch_tiler_top_macros.svh"

module shadow_dispatch_tiler_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [sdt_pkg::CFG_AW-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    sdt_in_if.sink                      i_light,
    sdt_out_if.source                   o_disp
);
    import sdt_pkg::*;

    typedef logic signed [27:0] t_crd;

    typedef struct packed {
        t_crd cx;
        t_crd cy;
        t_crd ox;
        t_crd oy;
    } t_rect;

    typedef struct packed {
        logic [8:0]  gx;
        logic [8:0]  gy;
        logic [31:0] ox;
        logic [31:0] oy;
    } t_slot;

    typedef struct packed {
        logic        neg_x;
        logic        neg_y;
        logic        neg_z;
        logic        wzero;
        logic        front;
        logic [14:0] vw;
        logic [14:0] vh;
    } t_side;

    typedef struct packed {
        logic signed [47:0] px;
        logic signed [47:0] py;
        logic signed [31:0] dep;
        logic               front;
    } t_lit;

    typedef struct packed {
        t_crd b0;
        t_crd b1;
        t_crd b2;
        t_crd b3;
        t_crd adc;
        logic adpos;
    } t_qb;

    typedef struct packed {
        logic  ok_a;
        logic  ok_b;
        t_slot a;
        t_slot b;
    } t_qs;

    localparam logic signed [31:0] W_LIM_S = 32'(W_LIM);

    function automatic t_crd shr_pos(input t_crd v);
        return v[27] ? t_crd'(0) : (v >>> WAVE_SH);
    endfunction

    function automatic logic signed [62:0] fix_quo(input logic [DIV_NW-1:0] q,
                                                   input logic neg, input logic nz);
        logic signed [62:0] r;
        if (neg) begin
            r = $signed(~{1'b0, q}) + $signed(63'(!nz));
        end else begin
            r = $signed({1'b0, q});
        end
        return r;
    endfunction

    function automatic logic signed [47:0] sat48(input logic signed [62:0] v);
        logic signed [47:0] r;
        if (v[62:47] != {16{v[62]}}) begin
            r = v[62] ? {1'b1, 47'b0} : {1'b0, {47{1'b1}}};
        end else begin
            r = v[47:0];
        end
        return r;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [62:0] v);
        logic signed [31:0] r;
        if (v[62:31] != {32{v[62]}}) begin
            r = v[62] ? {1'b1, 31'b0} : {1'b0, {31{1'b1}}};
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic t_crd round_px(input logic signed [47:0] p);
        logic signed [48:0] t;
        logic signed [32:0] r;
        t = $signed({p[47], p}) + ((p < -48'sd32768) ? 49'sd98303 : 49'sd32768);
        r = t[48:16];
        if (r > 33'sd16777216) begin
            r = 33'sd16777216;
        end else if (r < -33'sd16777216) begin
            r = -33'sd16777216;
        end
        return r[27:0];
    endfunction

    function automatic t_qb quad_b(input logic [1:0] q, input t_crd bb0, input t_crd bb1,
                                   input t_crd bb2, input t_crd bb3);
        t_qb  r;
        logic vert;
        t_crd s0, s1, s2, s3, ad;
        vert = (q == 2'd0) || (q == 2'd3);
        s0 = q[0] ? bb0 : -bb2;
        s1 = q[1] ? bb1 : -bb3;
        s2 = (q[0] ? bb2 : -bb0)
           + (vert ? t_crd'(WAVE_SIZE - 1) : t_crd'(2 * WAVE_SIZE - 1));
        s3 = (q[1] ? bb3 : -bb1)
           + (vert ? t_crd'(2 * WAVE_SIZE - 1) : t_crd'(WAVE_SIZE - 1));
        case (q)
            2'd0:    ad = bb0 - bb1;
            2'd1:    ad = bb2 + bb1;
            2'd2:    ad = -bb0 - bb3;
            default: ad = bb3 - bb2;
        endcase
        r.b0    = shr_pos(s0);
        r.b1    = shr_pos(s1);
        r.b2    = shr_pos(s2);
        r.b3    = shr_pos(s3);
        r.adpos = ad > t_crd'(0);
        r.adc   = shr_pos(ad + t_crd'(WAVE_SIZE - 1));
        return r;
    endfunction

    function automatic t_slot to_slot(input t_rect r);
        t_slot s;
        s.gx = r.cx[27] ? 9'd0 : ((r.cx > t_crd'(511)) ? 9'd511 : r.cx[8:0]);
        s.gy = r.cy[27] ? 9'd0 : ((r.cy > t_crd'(511)) ? 9'd511 : r.cy[8:0]);
        s.ox = 32'(r.ox) << WAVE_SH;
        s.oy = 32'(r.oy) << WAVE_SH;
        return s;
    endfunction

    function automatic t_qs quad_split(input logic [1:0] q, input t_qb qb);
        t_qs   r;
        t_rect ra, rb;
        t_crd  cx, cy, mx, my;
        logic  oka, okb;
        cx    = qb.b2 - qb.b0;
        cy    = qb.b3 - qb.b1;
        ra.cx = cx;
        ra.cy = cy;
        ra.ox = (q[0] ? qb.b0 : -qb.b2) + (q[1] ? t_crd'(1) : t_crd'(0));
        ra.oy = (q[1] ? -qb.b3 : qb.b1) + (q[0] ? t_crd'(1) : t_crd'(0));
        rb    = ra;
        oka   = 1'b1;
        okb   = 1'b0;
        mx    = (cx < qb.adc) ? cx : qb.adc;
        my    = (cy < qb.adc) ? cy : qb.adc;
        if (qb.adpos) begin
            case (q)
                2'd0: begin
                    rb.cy = my;
                    ra.cy = cy - my;
                    rb.oy = ra.oy + ra.cy;
                    rb.ox = ra.ox - t_crd'(1);
                    rb.cx = cx + t_crd'(1);
                end
                2'd1: begin
                    rb.cx = mx;
                    ra.cx = cx - mx;
                    rb.ox = ra.ox + ra.cx;
                    rb.cy = cy + t_crd'(1);
                end
                2'd2: begin
                    rb.cx = mx;
                    ra.cx = cx - mx;
                    ra.ox = ra.ox + mx;
                    rb.cy = cy + t_crd'(1);
                    rb.oy = ra.oy - t_crd'(1);
                end
                default: begin
                    rb.cy = my;
                    ra.cy = cy - my;
                    ra.oy = ra.oy + my;
                    rb.cx = cx + t_crd'(1);
                end
            endcase
            oka = (ra.cx > t_crd'(0)) && (ra.cy > t_crd'(0));
            okb = (rb.cx > t_crd'(0)) && (rb.cy > t_crd'(0));
        end
        if (cx <= t_crd'(0) || cy <= t_crd'(0)) begin
            oka = 1'b0;
            okb = 1'b0;
        end
        r.ok_a = oka;
        r.ok_b = okb;
        r.a    = to_slot(ra);
        r.b    = to_slot(rb);
        return r;
    endfunction

    // config registers
    logic [14:0] r_vw, r_vh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vw <= VW_RESET;
            r_vh <= VH_RESET;
        end else if (psel && penable && pwrite && pready) begin
            case (t_reg_idx'(paddr[2]))
                REG_VIEWPORT_WIDTH:  r_vw <= pwdata[14:0];
                REG_VIEWPORT_HEIGHT: r_vh <= pwdata[14:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (t_reg_idx'(paddr[2]))
            REG_VIEWPORT_WIDTH:  prdata = {17'b0, r_vw};
            REG_VIEWPORT_HEIGHT: prdata = {17'b0, r_vh};
            default:             prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    logic en;
    logic accept;

    assign i_light.ready = en;
    assign accept        = i_light.valid && i_light.ready;

    // stage 1: scale by viewport, clamp w
    logic               r1_v;
    logic signed [47:0] r1_px, r1_py;
    logic signed [31:0] r1_z, r1_w, r1_wc;
    logic [14:0]        r1_vw, r1_vh;
    logic signed [31:0] wc;

    always_comb begin
        wc = i_light.light_proj_w;
        if (!wc[31] && wc < W_LIM_S) begin
            wc = W_LIM_S;
        end else if (wc[31] && wc > -W_LIM_S) begin
            wc = -W_LIM_S;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (en) begin
            r1_v <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_px <= i_light.light_proj_x * $signed({1'b0, r_vw});
            r1_py <= i_light.light_proj_y * $signed({1'b0, r_vh});
            r1_z  <= i_light.light_proj_z;
            r1_w  <= i_light.light_proj_w;
            r1_wc <= wc;
            r1_vw <= r_vw;
            r1_vh <= r_vh;
        end
    end

    // divider feed
    logic [47:0]        mag_x, mag_y;
    logic [31:0]        mag_z, mag_w, mag_wc;
    logic [DIV_NW-1:0]  num_x, num_y, num_z;
    logic [DIV_DW-1:0]  den_z;
    t_side              side_in;

    always_comb begin
        mag_x  = r1_px[47] ? 48'(-r1_px) : 48'(r1_px);
        mag_y  = r1_py[47] ? 48'(-r1_py) : 48'(r1_py);
        mag_z  = r1_z[31] ? 32'(-r1_z) : 32'(r1_z);
        mag_w  = r1_w[31] ? 32'(-r1_w) : 32'(r1_w);
        mag_wc = r1_wc[31] ? 32'(-r1_wc) : 32'(r1_wc);
        num_x  = {mag_x[46:0], 15'b0};
        num_y  = {mag_y[46:0], 15'b0};
        num_z  = {14'b0, mag_z, 16'b0};
        den_z  = (r1_w == 32'sd0) ? 32'd1 : mag_w;
        side_in.neg_x = r1_px[47] ^ r1_wc[31];
        side_in.neg_y = r1_py[47] ^ r1_wc[31];
        side_in.neg_z = r1_z[31] ^ r1_w[31];
        side_in.wzero = (r1_w == 32'sd0);
        side_in.front = !r1_w[31] && (r1_w != 32'sd0);
        side_in.vw    = r1_vw;
        side_in.vh    = r1_vh;
    end

    logic [DIV_NW-1:0] quo_x, quo_y, quo_z;
    logic              nz_x, nz_y, nz_z;

    sdt_div u_div_x (
        .i_clk(i_clk), .i_en(en), .i_num(num_x), .i_den(mag_wc),
        .o_quo(quo_x), .o_rem_nz(nz_x)
    );
    sdt_div u_div_y (
        .i_clk(i_clk), .i_en(en), .i_num(num_y), .i_den(mag_wc),
        .o_quo(quo_y), .o_rem_nz(nz_y)
    );
    sdt_div u_div_z (
        .i_clk(i_clk), .i_en(en), .i_num(num_z), .i_den(den_z),
        .o_quo(quo_z), .o_rem_nz(nz_z)
    );

    // sideband delay alongside the divider
    t_side              r_sd [DIV_LAT];
    logic [DIV_LAT-1:0] r_dv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv <= '0;
        end else if (en) begin
            r_dv <= {r_dv[DIV_LAT-2:0], r1_v};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sd[0] <= side_in;
            for (int k = 1; k < DIV_LAT; k++) begin
                r_sd[k] <= r_sd[k-1];
            end
        end
    end

    // stage p: floor fixup, offset, saturate
    t_side       sd_out;
    logic        r_p_v;
    t_lit        r_p_lit;
    logic [14:0] r_p_vw, r_p_vh;
    t_lit        p_lit;

    assign sd_out = r_sd[DIV_LAT-1];

    always_comb begin
        p_lit.px    = sat48(fix_quo(quo_x, sd_out.neg_x, nz_x)
                          + $signed(63'({sd_out.vw, 15'b0})));
        p_lit.py    = sat48(fix_quo(quo_y, sd_out.neg_y, nz_y)
                          + $signed(63'({sd_out.vh, 15'b0})));
        p_lit.dep   = sd_out.wzero ? 32'sd0 : sat32(fix_quo(quo_z, sd_out.neg_z, nz_z));
        p_lit.front = sd_out.front;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_v <= 1'b0;
        end else if (en) begin
            r_p_v <= r_dv[DIV_LAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p_lit <= p_lit;
            r_p_vw  <= sd_out.vw;
            r_p_vh  <= sd_out.vh;
        end
    end

    // stage l: round light position
    logic        r_l_v;
    t_lit        r_l_lit;
    t_crd        r_l_lx, r_l_ly;
    logic [14:0] r_l_vw, r_l_vh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_l_v <= 1'b0;
        end else if (en) begin
            r_l_v <= r_p_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_l_lit <= r_p_lit;
            r_l_lx  <= round_px(r_p_lit.px);
            r_l_ly  <= round_px(r_p_lit.py);
            r_l_vw  <= r_p_vw;
            r_l_vh  <= r_p_vh;
        end
    end

    // stage b: quadrant bounds in wave units
    logic r_b_v;
    t_lit r_b_lit;
    t_qb  r_b_qb [4];
    t_qb  b_qb   [4];
    t_crd bb0, bb1, bb2, bb3;

    always_comb begin
        bb0 = -r_l_lx;
        bb1 = r_l_ly - t_crd'(r_l_vh);
        bb2 = t_crd'(r_l_vw) - r_l_lx;
        bb3 = r_l_ly;
        for (int q = 0; q < 4; q++) begin
            b_qb[q] = quad_b(2'(q), bb0, bb1, bb2, bb3);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_v <= 1'b0;
        end else if (en) begin
            r_b_v <= r_l_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b_lit <= r_l_lit;
            for (int q = 0; q < 4; q++) begin
                r_b_qb[q] <= b_qb[q];
            end
        end
    end

    // stage q: rectangles and diagonal split
    logic       r_q_v;
    t_lit       r_q_lit;
    t_slot      r_q_slot [8];
    logic [7:0] r_q_ok;
    t_slot      q_slot   [8];
    logic [7:0] q_ok;

    always_comb begin
        t_qs qs;
        for (int q = 0; q < 4; q++) begin
            qs              = quad_split(2'(q), r_b_qb[q]);
            q_slot[2*q]     = qs.a;
            q_slot[2*q+1]   = qs.b;
            q_ok[2*q]       = qs.ok_a;
            q_ok[2*q+1]     = qs.ok_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_v <= 1'b0;
        end else if (en) begin
            r_q_v <= r_b_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_q_lit <= r_b_lit;
            r_q_ok  <= q_ok;
            for (int k = 0; k < 8; k++) begin
                r_q_slot[k] <= q_slot[k];
            end
        end
    end

    // output stage: one word per kept rectangle, or one empty word if none is kept
    logic       r_e_v;
    t_lit       r_e_lit;
    t_slot      r_e_slot [8];
    logic [7:0] r_e_mask;
    logic [2:0] sel_idx;
    logic [7:0] sel_oh;
    logic       e_last;
    logic       e_take;
    logic       e_dv;
    t_slot      e_slot;

    always_comb begin
        sel_idx = '0;
        for (int k = 7; k >= 0; k--) begin
            if (r_e_mask[k]) begin
                sel_idx = 3'(k);
            end
        end
        sel_oh = 8'b1 << sel_idx;
        e_last = (r_e_mask & ~sel_oh) == 8'b0;
        e_dv   = |r_e_mask;
        e_slot = r_e_slot[sel_idx];
    end

    assign e_take = r_e_v && o_disp.ready;
    assign en     = !r_e_v || (e_take && e_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_v    <= 1'b0;
            r_e_mask <= '0;
        end else if (en) begin
            r_e_v    <= r_q_v;
            r_e_mask <= r_q_ok;
        end else if (e_take) begin
            r_e_mask <= r_e_mask & ~sel_oh;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_e_lit <= r_q_lit;
            for (int k = 0; k < 8; k++) begin
                r_e_slot[k] <= r_q_slot[k];
            end
        end
    end

    assign o_disp.valid          = r_e_v;
    assign o_disp.light_pixel_x  = r_e_lit.px;
    assign o_disp.light_pixel_y  = r_e_lit.py;
    assign o_disp.light_depth    = r_e_lit.dep;
    assign o_disp.light_in_front = r_e_lit.front;
    assign o_disp.dispatch_valid = e_dv;
    assign o_disp.groups_x       = e_dv ? e_slot.gx : 9'd0;
    assign o_disp.groups_y       = e_dv ? e_slot.gy : 9'd0;
    assign o_disp.pixel_offset_x = e_dv ? e_slot.ox : 32'd0;
    assign o_disp.pixel_offset_y = e_dv ? e_slot.oy : 32'd0;
    assign o_disp.last           = e_last;

    `SDT_ASSERT_IMP(a_empty_is_last, o_disp.valid && !o_disp.dispatch_valid, o_disp.last)
    `SDT_ASSERT_IMP(a_rect_nonempty, o_disp.valid && o_disp.dispatch_valid, o_disp.groups_x != 9'd0 && o_disp.groups_y != 9'd0)
    `SDT_ASSERT_NXT(a_more_follow, o_disp.valid && o_disp.ready && !o_disp.last, o_disp.valid)
    `SDT_ASSERT_NXT(a_zero_w_depth, en && r_dv[DIV_LAT-1] && sd_out.wzero, r_p_lit.dep == 32'sd0)

endmodule

/* dv/shadow_dispatch_checker.sv */
module shadow_dispatch_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [sdt_pkg::CFG_AW-1:0] paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    sdt_in_if           lin,
    sdt_out_if          ldisp,
    output int          o_pending,
    output int          o_failures
);
    import sdt_pkg::*;

    typedef struct packed {
        logic signed [47:0] pix_x;
        logic signed [47:0] pix_y;
        logic signed [31:0] depth;
        logic               front;
        logic               dvalid;
        logic [8:0]         gx;
        logic [8:0]         gy;
        logic signed [31:0] offx;
        logic signed [31:0] offy;
        logic               last;
    } t_disp_word;

    typedef struct {
        longint cx, cy, ox, oy;
    } t_rect;

    t_disp_word disp_q[$];
    logic [14:0] vp_w, vp_h;

    function automatic longint fdiv(longint n, longint d);
        longint q;
        q = n / d;
        if ((n % d) != 0 && ((n < 0) != (d < 0)))
            q--;
        return q;
    endfunction

    function automatic longint clampl(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint pos0(longint v);
        return v > 0 ? v : 0;
    endfunction

    function automatic longint proj_pixel(longint c, longint sz, longint w);
        return clampl(fdiv(c * sz * 32768, w) + sz * 32768,
                      -(64'sd1 <<< 47), (64'sd1 <<< 47) - 1);
    endfunction

    function automatic longint snap_pixel(longint p);
        longint t, r;
        t = p + 32768;
        r = (t >= 0) ? (t >>> 16) : -((-t) >>> 16);
        return clampl(r, -(64'sd1 <<< 24), 64'sd1 <<< 24);
    endfunction

    task automatic tile_light(logic signed [31:0] cx_in, logic signed [31:0] cy_in,
                              logic signed [31:0] cz_in, logic signed [31:0] cw_in);
        longint ws, x, y, z, w, vw, vh, wc, px, py, dep, lx, ly;
        longint bb0, bb1, bb2, bb3, b0, b1, b2, b3, ad;
        bit vert;
        t_rect rl[$];
        t_rect a, b;
        t_disp_word e;
        int cnt;
        ws = WAVE_SIZE;
        x = cx_in; y = cy_in; z = cz_in; w = cw_in;
        vw = vp_w; vh = vp_h;
        wc = w;
        if (wc >= 0 && wc < W_LIM) wc = W_LIM;
        else if (wc < 0 && wc > -W_LIM) wc = -W_LIM;
        px = proj_pixel(x, vw, wc);
        py = proj_pixel(y, vh, wc);
        dep = 0;
        if (w != 0)
            dep = clampl(fdiv(z * 65536, w), -(64'sd1 <<< 31), (64'sd1 <<< 31) - 1);
        lx = snap_pixel(px);
        ly = snap_pixel(py);
        bb0 = -lx; bb1 = ly - vh; bb2 = vw - lx; bb3 = ly;
        for (int q = 0; q < 4; q++) begin
            vert = (q == 0 || q == 3);
            b0 = pos0(q[0] ? bb0 : -bb2) / ws;
            b1 = pos0(q[1] ? bb1 : -bb3) / ws;
            b2 = pos0((q[0] ? bb2 : -bb0) + ws * (vert ? 1 : 2) - 1) / ws;
            b3 = pos0((q[1] ? bb3 : -bb1) + ws * (vert ? 2 : 1) - 1) / ws;
            if (b2 - b0 <= 0 || b3 - b1 <= 0)
                continue;
            a.cx = b2 - b0;
            a.cy = b3 - b1;
            a.ox = (q[0] ? b0 : -b2) + (q >= 2 ? 1 : 0);
            a.oy = (q[1] ? -b3 : b1) + ((q == 1 || q == 3) ? 1 : 0);
            case (q)
                0: ad = bb0 - bb1;
                1: ad = bb2 + bb1;
                2: ad = -bb0 - bb3;
                default: ad = -bb2 + bb3;
            endcase
            if (ad <= 0) begin
                rl.push_back(a);
                continue;
            end
            ad = (ad + ws - 1) / ws;
            b = a;
            case (q)
                0: begin
                    b.cy = a.cy < ad ? a.cy : ad; a.cy -= b.cy;
                    b.oy = a.oy + a.cy; b.ox--; b.cx++;
                end
                1: begin
                    b.cx = a.cx < ad ? a.cx : ad; a.cx -= b.cx;
                    b.ox = a.ox + a.cx; b.cy++;
                end
                2: begin
                    b.cx = a.cx < ad ? a.cx : ad; a.cx -= b.cx;
                    a.ox += b.cx; b.cy++; b.oy--;
                end
                default: begin
                    b.cy = a.cy < ad ? a.cy : ad; a.cy -= b.cy;
                    a.oy += b.cy; b.cx++;
                end
            endcase
            if (a.cx > 0 && a.cy > 0) rl.push_back(a);
            if (b.cx > 0 && b.cy > 0) rl.push_back(b);
        end
        cnt = rl.size() > 0 ? rl.size() : 1;
        for (int k = 0; k < cnt; k++) begin
            e = '0;
            e.pix_x = px[47:0];
            e.pix_y = py[47:0];
            e.depth = dep[31:0];
            e.front = w > 0;
            if (rl.size() > 0) begin
                e.dvalid = 1'b1;
                e.gx = 9'(clampl(rl[k].cx, 0, 511));
                e.gy = 9'(clampl(rl[k].cy, 0, 511));
                e.offx = 32'(rl[k].ox * ws);
                e.offy = 32'(rl[k].oy * ws);
            end
            e.last = (k == cnt - 1);
            disp_q.push_back(e);
        end
    endtask

    task automatic cmp_field(string name, longint exp_v, longint act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0d actual %0d", name, exp_v, act_v);
            o_failures++;
        end
    endtask

    initial begin
        o_failures = 0;
        o_pending = 0;
        vp_w = VW_RESET;
        vp_h = VH_RESET;
    end

    always @(posedge i_clk) begin
        t_disp_word e;
        if (!i_rst_n) begin
            vp_w <= VW_RESET;
            vp_h <= VH_RESET;
        end else begin
            if (psel && penable && pwrite && pready) begin
                if (paddr[2] == REG_VIEWPORT_HEIGHT) vp_h <= pwdata[14:0];
                else vp_w <= pwdata[14:0];
            end
            if (lin.valid && lin.ready)
                tile_light(lin.light_proj_x, lin.light_proj_y,
                           lin.light_proj_z, lin.light_proj_w);
            if (ldisp.valid && ldisp.ready) begin
                if (disp_q.size() == 0) begin
                    $error("unexpected dispatch word");
                    o_failures++;
                end else begin
                    e = disp_q.pop_front();
                    cmp_field("light_pixel_x", e.pix_x, ldisp.light_pixel_x);
                    cmp_field("light_pixel_y", e.pix_y, ldisp.light_pixel_y);
                    cmp_field("light_depth", e.depth, ldisp.light_depth);
                    cmp_field("light_in_front", e.front, ldisp.light_in_front);
                    cmp_field("dispatch_valid", e.dvalid, ldisp.dispatch_valid);
                    cmp_field("groups_x", e.gx, ldisp.groups_x);
                    cmp_field("groups_y", e.gy, ldisp.groups_y);
                    cmp_field("pixel_offset_x", e.offx, ldisp.pixel_offset_x);
                    cmp_field("pixel_offset_y", e.offy, ldisp.pixel_offset_y);
                    cmp_field("last", e.last, ldisp.last);
                end
            end
            o_pending = disp_q.size();
        end
    end
endmodule

/* dv/tb_top.sv */
module tb_top;
    import sdt_pkg::*;

    localparam int LIMIT = 600000;
    localparam int DRAIN = 80;

    logic i_clk, i_rst_n;
    logic psel, penable, pwrite, pready;
    logic [CFG_AW-1:0] paddr;
    logic [31:0] pwdata, prdata;
    int pending, failures;
    int send_idle_pct, recv_stall_pct, hold_cycles;
    longint cyc;

    sdt_in_if light_if();
    sdt_out_if disp_if();

    shadow_dispatch_tiler_top uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .i_light(light_if), .o_disp(disp_if)
    );

    shadow_dispatch_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready),
        .lin(light_if), .ldisp(disp_if),
        .o_pending(pending), .o_failures(failures)
    );

    initial begin
        i_clk = 0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc > LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // receiver side
    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            disp_if.ready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end else begin
            disp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic reg_write(t_reg_idx idx, logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_light(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                              logic [31:0] w);
        while ($urandom_range(99) < send_idle_pct) begin
            light_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        light_if.valid <= 1'b1;
        light_if.light_proj_x <= x;
        light_if.light_proj_y <= y;
        light_if.light_proj_z <= z;
        light_if.light_proj_w <= w;
        @(posedge i_clk);
        while (!light_if.ready) @(posedge i_clk);
    endtask

    task automatic settle();
        light_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    task automatic set_viewport(logic [14:0] vw, logic [14:0] vh);
        settle();
        reg_write(REG_VIEWPORT_WIDTH, {17'd0, vw});
        reg_write(REG_VIEWPORT_HEIGHT, {17'd0, vh});
    endtask

    // mostly lights that land near the screen, some full-range noise
    task automatic random_light();
        longint w, x, y;
        if ($urandom_range(99) < 20) begin
            send_light($urandom, $urandom, $urandom, $urandom);
        end else begin
            w = $urandom_range(32'h0080_0000, 32'h0000_4000);
            x = longint'($urandom_range(2 * w, 0)) - w;
            y = longint'($urandom_range(2 * w, 0)) - w;
            x = x + x / 4;
            y = y + y / 4;
            if ($urandom_range(9) == 0) w = -w;
            send_light(x[31:0], y[31:0], $urandom, w[31:0]);
        end
    endtask

    task automatic random_batch(int n);
        for (int i = 0; i < n; i++)
            random_light();
    endtask

    initial begin
        cyc = 0;
        i_rst_n = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        light_if.valid = 1'b0;
        light_if.light_proj_x = '0; light_if.light_proj_y = '0;
        light_if.light_proj_z = '0; light_if.light_proj_w = '0;
        disp_if.ready = 1'b0;
        send_idle_pct = 0; recv_stall_pct = 0; hold_cycles = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: center, corners, extremes, zero and tiny w
        send_light(32'h0, 32'h0, 32'h0001_0000, 32'h0001_0000);
        send_light(32'h0001_0000, 32'h0001_0000, 32'h0, 32'h0001_0000);
        send_light(32'hFFFF_0000, 32'hFFFF_0000, 32'h0, 32'h0001_0000);
        send_light(32'h0000_8000, 32'hFFFF_8000, 32'h0000_4000, 32'h0001_0000);
        send_light(32'h0, 32'h0, 32'h0001_0000, 32'h0);
        send_light(32'h0001_0000, 32'hFFFF_0000, 32'h7FFF_FFFF, 32'h0000_0001);
        send_light(32'h0001_0000, 32'h0001_0000, 32'h8000_0000, 32'hFFFF_FFFF);
        send_light(32'h0, 32'h0, 32'h0, 32'h0000_0008);
        send_light(32'h0, 32'h0, 32'h0, 32'hFFFF_FFF8);
        send_light(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_light(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_light(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h0000_0002);
        send_light(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_light(32'h0003_0000, 32'h0, 32'h0, 32'h0001_0000);
        send_light(32'h0, 32'h0003_0000, 32'h0, 32'hFFFF_0000);
        send_light(32'h0000_4000, 32'h0000_C000, 32'h0002_0000, 32'h0001_0000);
        set_viewport(15'd0, 15'd32767);
        send_light(32'h0, 32'h0, 32'h0, 32'h0001_0000);
        send_light(32'h0000_8000, 32'h0000_8000, 32'h0, 32'h0001_0000);
        set_viewport(15'd1, 15'd1);
        send_light(32'h0, 32'h0, 32'h0, 32'h0001_0000);
        send_light(32'h7FFF_FFFF, 32'h0, 32'h0, 32'h0000_0003);

        set_viewport(15'd1920, 15'd1080);
        random_batch(60);
        set_viewport(15'd16384, 15'd16384);
        send_idle_pct = 75;
        random_batch(50);
        set_viewport(15'd32767, 15'd1);
        send_idle_pct = 0; recv_stall_pct = 75;
        random_batch(50);
        set_viewport(15'($urandom_range(4096, 1)), 15'($urandom_range(4096, 1)));
        send_idle_pct = 16; recv_stall_pct = 16;
        random_batch(50);

        // long receiver hold-off while lights keep coming
        set_viewport(15'd1920, 15'd1080);
        send_idle_pct = 0; recv_stall_pct = 0;
        hold_cycles <= 400;
        random_batch(40);
        settle();
        random_batch(10);
        settle();

        if (failures == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
